// ===== sv/atpt_pkg.sv =====
// Shared types and constants for the attitude PID with tilt compensated thrust.
// Holds the item structs, the datapath command word, operation codes and trig tables.
// No dependencies.
package atpt_pkg;

  // One control tick in
  typedef struct packed {
    logic signed [15:0] ref_roll;
    logic signed [15:0] ref_pitch;
    logic signed [15:0] ref_yaw;
    logic        [15:0] ref_thrust;
    logic signed [15:0] meas_roll;
    logic signed [15:0] meas_pitch;
    logic signed [15:0] meas_yaw;
  } in_t;

  // One set of actuator commands out
  typedef struct packed {
    logic signed [15:0] roll_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_cmd;
    logic        [15:0] thrust_cmd;
  } out_t;

  typedef logic [47:0] gains_t;

  // Datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_STORE    = 4'd3;
  localparam logic [3:0] OP_PID_UPD  = 4'd4;
  localparam logic [3:0] OP_ANG_INIT = 4'd5;
  localparam logic [3:0] OP_RED      = 4'd6;
  localparam logic [3:0] OP_FOLD     = 4'd7;
  localparam logic [3:0] OP_CORDIC   = 4'd8;
  localparam logic [3:0] OP_DIV_INIT = 4'd9;
  localparam logic [3:0] OP_DIV      = 4'd10;
  localparam logic [3:0] OP_SQ_INIT  = 4'd11;
  localparam logic [3:0] OP_SQRT     = 4'd12;
  localparam logic [3:0] OP_FINISH   = 4'd13;

  // Multiplier operand selections
  localparam logic [2:0] M_PID  = 3'd0;
  localparam logic [2:0] M_SQX  = 3'd1;
  localparam logic [2:0] M_SQY  = 3'd2;
  localparam logic [2:0] M_CRCP = 3'd3;
  localparam logic [2:0] M_SRCP = 3'd4;
  localparam logic [2:0] M_SPCR = 3'd5;
  localparam logic [2:0] M_T2   = 3'd6;
  localparam logic [2:0] M_TN   = 3'd7;

  // Command word from the sequencer to the datapath
  typedef struct packed {
    logic [3:0] op;
    logic [2:0] msel;
    logic [4:0] idx;
    logic [1:0] axis;
  } cmd_t;

  // Register map
  localparam int APB_AW = 5;
  localparam logic [1:0] REG_ROLL_GAINS  = 2'd0;
  localparam logic [1:0] REG_PITCH_GAINS = 2'd1;
  localparam logic [1:0] REG_YAW_GAINS   = 2'd2;

  localparam int GAIN_FRAC    = 12;
  localparam int TRIG_FRAC    = 30;
  localparam int ANG_Q        = 28;
  localparam int CORDIC_STEPS = 28;
  localparam int PI_Q28          = 843314857;
  localparam int HALF_PI_Q28     = 421657428;
  localparam int CORDIC_GAIN_Q30 = 652032874;

  localparam logic signed [31:0] ATAN_Q28 [CORDIC_STEPS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
    32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
    32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2
  };

endpackage

// ===== sv/atpt_ctrl.sv =====
// Sequencer for the attitude PID: walks one item through PID, trig, divide and root.
// Drives the datapath by atpt_pkg::cmd_t and owns both channel handshakes.
// Depends on atpt_pkg.
module atpt_ctrl #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output atpt_pkg::cmd_t  cmd
);

  localparam int ANG_SH    = atpt_pkg::ANG_Q - ANGLE_FRAC_BITS;
  localparam int RED_STEPS = ANG_SH - 13;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PID   = 4'd1;
  localparam logic [3:0] S_AINIT = 4'd2;
  localparam logic [3:0] S_RED   = 4'd3;
  localparam logic [3:0] S_FOLD  = 4'd4;
  localparam logic [3:0] S_CORD  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_PROD  = 4'd7;
  localparam logic [3:0] S_DIVI  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_SQI   = 4'd10;
  localparam logic [3:0] S_SQRT  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] axis, axis_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  // Next state and command
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    axis_next      = axis;
    out_valid_next = out_valid && out_stall;
    cmd.op         = atpt_pkg::OP_NOP;
    cmd.msel       = atpt_pkg::M_PID;
    cmd.idx        = cnt;
    cmd.axis       = axis;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = atpt_pkg::OP_LOAD;
          state_next = S_PID;
          cnt_next   = '0;
          axis_next  = '0;
        end
      end
      S_PID: begin
        cmd.idx = {3'b000, cnt[2:1]};
        if (cnt == 5'd6) begin
          cmd.op   = atpt_pkg::OP_PID_UPD;
          cnt_next = '0;
          if (axis == 2'd2) begin
            axis_next  = '0;
            state_next = S_AINIT;
          end else begin
            axis_next = axis + 2'd1;
          end
        end else begin
          cmd.op   = cnt[0] ? atpt_pkg::OP_STORE : atpt_pkg::OP_MUL;
          cnt_next = cnt + 5'd1;
        end
      end
      S_AINIT: begin
        cmd.op     = atpt_pkg::OP_ANG_INIT;
        state_next = S_RED;
        cnt_next   = 5'(RED_STEPS - 1);
      end
      S_RED: begin
        cmd.op = atpt_pkg::OP_RED;
        if (cnt == 5'd0) state_next = S_FOLD;
        else cnt_next = cnt - 5'd1;
      end
      S_FOLD: begin
        cmd.op     = atpt_pkg::OP_FOLD;
        state_next = S_CORD;
        cnt_next   = '0;
      end
      S_CORD: begin
        cmd.op = atpt_pkg::OP_CORDIC;
        if (cnt == 5'(atpt_pkg::CORDIC_STEPS - 1)) begin
          state_next = S_SQ;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_SQ: begin
        cmd.msel = cnt[1] ? atpt_pkg::M_SQY : atpt_pkg::M_SQX;
        cmd.op   = cnt[0] ? atpt_pkg::OP_STORE : atpt_pkg::OP_MUL;
        if (cnt == 5'd3) begin
          cnt_next = '0;
          if (axis == 2'd0) begin
            axis_next  = 2'd1;
            state_next = S_AINIT;
          end else begin
            state_next = S_PROD;
          end
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_PROD: begin
        cmd.op = cnt[0] ? atpt_pkg::OP_STORE : atpt_pkg::OP_MUL;
        case (cnt[3:1])
          3'd0:    cmd.msel = atpt_pkg::M_CRCP;
          3'd1:    cmd.msel = atpt_pkg::M_SRCP;
          3'd2:    cmd.msel = atpt_pkg::M_SPCR;
          3'd3:    cmd.msel = atpt_pkg::M_T2;
          default: cmd.msel = atpt_pkg::M_TN;
        endcase
        if (cnt == 5'd9) state_next = S_DIVI;
        else cnt_next = cnt + 5'd1;
      end
      S_DIVI: begin
        cmd.op     = atpt_pkg::OP_DIV_INIT;
        state_next = S_DIV;
        cnt_next   = 5'd31;
      end
      S_DIV: begin
        cmd.op = atpt_pkg::OP_DIV;
        if (cnt == 5'd0) state_next = S_SQI;
        else cnt_next = cnt - 5'd1;
      end
      S_SQI: begin
        cmd.op     = atpt_pkg::OP_SQ_INIT;
        state_next = S_SQRT;
        cnt_next   = 5'd15;
      end
      S_SQRT: begin
        cmd.op = atpt_pkg::OP_SQRT;
        if (cnt == 5'd0) state_next = S_DONE;
        else cnt_next = cnt - 5'd1;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.op         = atpt_pkg::OP_FINISH;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      axis      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/atpt_dp.sv =====
// Datapath for the attitude PID: PID state, shared multiplier, CORDIC, divider, root.
// Executes one atpt_pkg::cmd_t per cycle and holds the output register.
// Depends on atpt_pkg.
module atpt_dp #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int ACC_WIDTH       = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  atpt_pkg::in_t           in_data,
  input  atpt_pkg::gains_t [2:0]  gains,
  input  atpt_pkg::cmd_t          cmd,
  output atpt_pkg::out_t          out_data
);

  localparam int ANG_SH = atpt_pkg::ANG_Q - ANGLE_FRAC_BITS;
  localparam int RED_W  = 16 + ANG_SH + 2;
  localparam int SUM_W  = ((ACC_WIDTH > 38) ? ACC_WIDTH : 38) + 2;
  localparam int MUL_W  = 34;
  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] CMD_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] CMD_MIN = -SUM_W'(32768);

  atpt_pkg::in_t item;
  logic signed [16:0]          prev_error  [3];
  logic signed [16:0]          older_error [3];
  logic signed [ACC_WIDTH-1:0] prev_output [3];
  logic signed [15:0]          pid_cmd     [3];
  logic signed [SUM_W-1:0]     sum;
  logic signed [2*MUL_W-1:0]   prod;
  logic                        ang_neg;
  logic [RED_W-1:0]            mag;
  logic signed [32:0]          xc, yc;
  logic signed [31:0]          zc;
  logic [31:0]                 cr2, sr2, cp2, sp2, dd, t2;
  logic [32:0]                 nn;
  logic [65:0]                 tn;
  logic [33:0]                 rem;
  logic [31:0]                 quo;
  logic                        ovf;
  logic [31:0]                 sq_op, sq_res, sq_one;
  atpt_pkg::out_t              out_q;

  assign out_data = out_q;

  // Per-axis selection
  atpt_pkg::gains_t   g;
  logic signed [15:0] ref_a, meas_a;
  always_comb begin
    case (cmd.axis)
      2'd0:    begin g = gains[0]; ref_a = item.ref_roll;  meas_a = item.meas_roll;  end
      2'd1:    begin g = gains[1]; ref_a = item.ref_pitch; meas_a = item.meas_pitch; end
      default: begin g = gains[2]; ref_a = item.ref_yaw;   meas_a = item.meas_yaw;   end
    endcase
  end

  logic [15:0]        kp, ki, kd;
  logic [17:0]        a0u, a1u;
  logic signed [16:0] e_cur;
  assign kp    = g[15:0];
  assign ki    = g[31:16];
  assign kd    = g[47:32];
  assign a0u   = 18'(kp) + 18'(ki) + 18'(kd);
  assign a1u   = 18'(kp) + {1'b0, kd, 1'b0};
  assign e_cur = 17'(ref_a) - 17'(meas_a);

  // Operand selection for the shared multiplier
  logic signed [MUL_W-1:0] mul_a, mul_b;
  always_comb begin
    case (cmd.msel)
      atpt_pkg::M_PID: begin
        case (cmd.idx[1:0])
          2'd0: begin
            mul_a = $signed(MUL_W'(a0u));
            mul_b = MUL_W'(e_cur);
          end
          2'd1: begin
            mul_a = -$signed(MUL_W'(a1u));
            mul_b = MUL_W'(prev_error[cmd.axis]);
          end
          default: begin
            mul_a = $signed(MUL_W'(kd));
            mul_b = MUL_W'(older_error[cmd.axis]);
          end
        endcase
      end
      atpt_pkg::M_SQX:  begin mul_a = MUL_W'(xc); mul_b = MUL_W'(xc); end
      atpt_pkg::M_SQY:  begin mul_a = MUL_W'(yc); mul_b = MUL_W'(yc); end
      atpt_pkg::M_CRCP: begin mul_a = $signed(MUL_W'(cr2)); mul_b = $signed(MUL_W'(cp2)); end
      atpt_pkg::M_SRCP: begin mul_a = $signed(MUL_W'(sr2)); mul_b = $signed(MUL_W'(cp2)); end
      atpt_pkg::M_SPCR: begin mul_a = $signed(MUL_W'(sp2)); mul_b = $signed(MUL_W'(cr2)); end
      atpt_pkg::M_T2: begin
        mul_a = $signed(MUL_W'(item.ref_thrust));
        mul_b = $signed(MUL_W'(item.ref_thrust));
      end
      default: begin mul_a = $signed(MUL_W'(t2)); mul_b = $signed(MUL_W'(nn)); end
    endcase
  end

  // Accumulator update with saturation
  logic signed [SUM_W-1:0]     tot, acc_ext, sh_ext;
  logic signed [ACC_WIDTH-1:0] acc_new;
  logic signed [15:0]          cmd_new;
  always_comb begin
    tot = SUM_W'(prev_output[cmd.axis]) + sum;
    if (tot > ACC_MAX) acc_ext = ACC_MAX;
    else if (tot < ACC_MIN) acc_ext = ACC_MIN;
    else acc_ext = tot;
    acc_new = ACC_WIDTH'(acc_ext);
    sh_ext  = acc_ext >>> atpt_pkg::GAIN_FRAC;
    if (sh_ext > CMD_MAX) cmd_new = 16'sh7fff;
    else if (sh_ext < CMD_MIN) cmd_new = -16'sh8000;
    else cmd_new = 16'(sh_ext);
  end

  // Angle scaling, range reduction and fold into half a turn
  logic signed [15:0]      raw_ang;
  logic signed [RED_W-1:0] ang_c;
  logic [RED_W-1:0]        pi_k;
  logic signed [31:0]      z0, zf;
  always_comb begin
    raw_ang = (cmd.axis == 2'd0) ? item.meas_roll : item.meas_pitch;
    ang_c   = RED_W'(raw_ang) <<< ANG_SH;
    pi_k    = RED_W'(atpt_pkg::PI_Q28) << cmd.idx;
    z0      = ang_neg ? -$signed(32'(mag)) : $signed(32'(mag));
    if (z0 > 32'(atpt_pkg::HALF_PI_Q28)) zf = z0 - 32'(atpt_pkg::PI_Q28);
    else if (z0 < -32'(atpt_pkg::HALF_PI_Q28)) zf = z0 + 32'(atpt_pkg::PI_Q28);
    else zf = z0;
  end

  // CORDIC micro-rotation
  logic signed [32:0] dx, dy;
  assign dx = yc >>> cmd.idx;
  assign dy = xc >>> cmd.idx;

  // Division and root steps
  logic [33:0] r2;
  logic [31:0] tn_lo;
  logic [32:0] sq_t;
  assign tn_lo = tn[31:0];
  assign r2    = {rem[32:0], tn_lo[cmd.idx]};
  assign sq_t  = 33'(sq_res) + 33'(sq_one);

  // PID state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        prev_error[i]  <= '0;
        older_error[i] <= '0;
        prev_output[i] <= '0;
      end
    end else if (cmd.op == atpt_pkg::OP_PID_UPD) begin
      prev_output[cmd.axis] <= acc_new;
      older_error[cmd.axis] <= prev_error[cmd.axis];
      prev_error[cmd.axis]  <= e_cur;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      atpt_pkg::OP_LOAD: begin
        item <= in_data;
        sum  <= '0;
      end
      atpt_pkg::OP_MUL: prod <= mul_a * mul_b;
      atpt_pkg::OP_STORE: begin
        case (cmd.msel)
          atpt_pkg::M_PID: sum <= sum + SUM_W'(prod);
          atpt_pkg::M_SQX: begin
            if (cmd.axis == 2'd0) cr2 <= prod[61:30];
            else cp2 <= prod[61:30];
          end
          atpt_pkg::M_SQY: begin
            if (cmd.axis == 2'd0) sr2 <= prod[61:30];
            else sp2 <= prod[61:30];
          end
          atpt_pkg::M_CRCP: begin
            dd <= prod[61:30];
            nn <= {1'b0, prod[61:30]};
          end
          atpt_pkg::M_SRCP, atpt_pkg::M_SPCR: nn <= nn + 33'(prod[61:30]);
          atpt_pkg::M_T2: t2 <= prod[31:0];
          default: tn <= prod[65:0];
        endcase
      end
      atpt_pkg::OP_PID_UPD: begin
        pid_cmd[cmd.axis] <= cmd_new;
        sum <= '0;
      end
      atpt_pkg::OP_ANG_INIT: begin
        ang_neg <= ang_c[RED_W-1];
        mag     <= ang_c[RED_W-1] ? RED_W'(-ang_c) : RED_W'(ang_c);
      end
      atpt_pkg::OP_RED: begin
        if (mag >= pi_k) mag <= mag - pi_k;
      end
      atpt_pkg::OP_FOLD: begin
        xc <= 33'(atpt_pkg::CORDIC_GAIN_Q30);
        yc <= '0;
        zc <= zf;
      end
      atpt_pkg::OP_CORDIC: begin
        if (!zc[31]) begin
          xc <= xc - dx;
          yc <= yc + dy;
          zc <= zc - atpt_pkg::ATAN_Q28[cmd.idx];
        end else begin
          xc <= xc + dx;
          yc <= yc - dy;
          zc <= zc + atpt_pkg::ATAN_Q28[cmd.idx];
        end
      end
      atpt_pkg::OP_DIV_INIT: begin
        rem <= tn[65:32];
        ovf <= (tn[65:32] >= {2'b00, dd});
        quo <= '0;
      end
      atpt_pkg::OP_DIV: begin
        if (r2 >= {2'b00, dd}) begin
          rem           <= r2 - {2'b00, dd};
          quo[cmd.idx]  <= 1'b1;
        end else begin
          rem <= r2;
        end
      end
      atpt_pkg::OP_SQ_INIT: begin
        sq_op  <= quo;
        sq_res <= '0;
        sq_one <= 32'h4000_0000;
      end
      atpt_pkg::OP_SQRT: begin
        if ({1'b0, sq_op} >= sq_t) begin
          sq_op  <= sq_op - sq_t[31:0];
          sq_res <= (sq_res >> 1) + sq_one;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_one <= sq_one >> 2;
      end
      atpt_pkg::OP_FINISH: begin
        out_q.roll_cmd  <= pid_cmd[0];
        out_q.pitch_cmd <= pid_cmd[1];
        out_q.yaw_cmd   <= pid_cmd[2];
        if (item.ref_thrust == 16'd0) out_q.thrust_cmd <= 16'd0;
        else if (ovf) out_q.thrust_cmd <= 16'hffff;
        else out_q.thrust_cmd <= sq_res[15:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/attitude_pid_tilt_thrust.sv =====
// Channel   | Signals                          | Accepted when
// in        | in_valid, in_stall, in_data      | in_valid && !in_stall
// out       | out_valid, out_stall, out_data   | out_valid && !out_stall
// config    | psel, penable, pwrite, paddr ... | psel && penable && pwrite && pready
//
// Each item passes through the 28-step CORDIC, run once per tilt angle, the 32-step
// divider and the 16-step root; the PID terms, squares and thrust products share one
// 34x34 multiplier. Items are handled one at a time.
// Reset is synchronous and clears PID history, gains and handshake state.
// A new item is accepted while the previous result still waits behind out_stall.
// Top level: APB gain registers, sequencer and datapath. Depends on atpt_pkg,
// atpt_ctrl and atpt_dp.
module attitude_pid_tilt_thrust #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int ACC_WIDTH       = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  atpt_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output atpt_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [atpt_pkg::APB_AW-1:0]  paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  atpt_pkg::gains_t [2:0] gains;
  atpt_pkg::cmd_t         cmd;
  logic [1:0]             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  // Gain registers: the user must time writes so they take effect from the next item; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        atpt_pkg::REG_ROLL_GAINS:  gains[0] <= pwdata[47:0];
        atpt_pkg::REG_PITCH_GAINS: gains[1] <= pwdata[47:0];
        atpt_pkg::REG_YAW_GAINS:   gains[2] <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      atpt_pkg::REG_ROLL_GAINS:  prdata = {16'h0000, gains[0]};
      atpt_pkg::REG_PITCH_GAINS: prdata = {16'h0000, gains[1]};
      atpt_pkg::REG_YAW_GAINS:   prdata = {16'h0000, gains[2]};
      default:                   prdata = '0;
    endcase
  end

  atpt_ctrl #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  atpt_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .gains    (gains),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

// ===== sv/atpt_checker.sv =====
// Port-level checks for attitude_pid_tilt_thrust, bound to the top level.
// Depends on atpt_pkg.
module atpt_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input atpt_pkg::out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // Busy straight after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // A new result only appears at the end of a busy spell
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

endmodule

bind attitude_pid_tilt_thrust atpt_checker u_chk (.*);
